// ----- hdl/hci_pkg.sv -----
package hci_pkg;

  // field widths
  localparam int COLOR_W = 24;
  localparam int PCT_W = 7;
  localparam int FRAC_BITS_DEF = 16;

  // fixed divisors and percent limit
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [10:0] LIGHT_DEN = 11'd510;
  localparam logic [6:0] PCT_DEN = 7'd100;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  // ramp segment of a hue channel
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } hci_seg_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } hci_qstat_t;

  // per colour values ahead of the dividers
  typedef struct packed {
    logic [8:0]  sum;
    logic [7:0]  d;
    logic [10:0] n;
    logic [7:0]  den_s;
    logic [10:0] sixd;
    logic        grey;
  } hci_rgb_info_t;

  // max, min and hue numerator of one colour
  function automatic hci_rgb_info_t hci_rgb_info(input logic [COLOR_W-1:0] c);
    logic [7:0] r, g, b, mx, mn, d;
    logic [10:0] sixd;
    logic signed [11:0] n;
    hci_rgb_info_t o;
    r = c[7:0];
    g = c[15:8];
    b = c[23:16];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sixd = 11'({3'b0, d}) * 11'd6;
    o.sum = {1'b0, mx} + {1'b0, mn};
    o.grey = (mx == mn);
    o.den_s = (o.sum < 9'd255) ? o.sum[7:0] : 8'(9'd510 - o.sum);
    if (r == mx) begin
      n = $signed({4'b0, g}) - $signed({4'b0, b});
    end else if (g == mx) begin
      n = $signed({3'b0, d, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
    end else begin
      n = $signed({2'b0, d, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
    end
    if (n < 0) n = n + $signed({1'b0, sixd});
    o.n = 11'(n);
    o.d = d;
    o.sixd = sixd;
    return o;
  endfunction

endpackage

// ----- hdl/hci_div.sv -----
module hci_div
  import hci_pkg::*;
#(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11,
  parameter int Q_W = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   q
);

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [NUM_W-1:0] trial;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in = q_r[i-1];
    end

    assign trial = NUM_W'(den_in) << (Q_W - 1 - i);
    assign take = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? rem_in - trial : rem_in;
        den_r[i] <= den_in;
        q_r[i] <= take ? (q_in | (Q_W'(1) << (Q_W - 1 - i))) : q_in;
      end
    end
  end

  assign q = q_r[Q_W-1];

endmodule

// ----- hdl/hci_front.sv -----
module hci_front
  import hci_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COLOR_W-1:0]   in_start_color,
  input  logic [COLOR_W-1:0]   in_end_color,
  input  logic [PCT_W-1:0]     in_blend_percent,
  input  hci_qstat_t           q_stat,
  output logic                 q_push,
  output logic [FRAC_BITS:0]   push_h,
  output logic [FRAC_BITS:0]   push_s,
  output logic [FRAC_BITS:0]   push_l,
  output logic                 push_byp,
  output logic [COLOR_W-1:0]   push_color
);

  localparam int W = FRAC_BITS + 1;
  localparam int L = W;
  localparam int NUM1_W = FRAC_BITS + 11;
  localparam int NUM2_W = FRAC_BITS + 8;

  // lightness as sum * LQ0 + (sum * LR0) / 510, the last part by reciprocal
  localparam int LQ0 = (2 ** FRAC_BITS) / int'(LIGHT_DEN);
  localparam int LR0 = (2 ** FRAC_BITS) % int'(LIGHT_DEN);
  localparam int LY_W = 18;
  localparam int LM_SH = 27;
  localparam logic [18:0] LM =
    19'(((2 ** LM_SH) + int'(LIGHT_DEN) - 1) / int'(LIGHT_DEN));

  // divide by one hundred by reciprocal
  localparam int PM_SH = FRAC_BITS + 14;
  localparam logic [NUM2_W-1:0] PM =
    NUM2_W'(((longint'(1) << PM_SH) + longint'(PCT_DEN) - 1) / longint'(PCT_DEN));

  typedef struct packed {
    logic             grey_a;
    logic             grey_b;
    logic [PCT_W-1:0] p;
    logic             byp;
    logic [COLOR_W-1:0] color;
  } side1_t;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0]        neg;
    logic              byp;
    logic [COLOR_W-1:0] color;
  } side2_t;

  logic en;

  logic               s1_valid_r;
  logic [COLOR_W-1:0] s1_sc_r, s1_ec_r;
  logic [PCT_W-1:0]   s1_p_r;
  logic [PCT_W-1:0]   p_clamp;

  logic          s2_valid_r;
  hci_rgb_info_t s2_a_r, s2_b_r;
  side1_t        s2_side_r;

  logic [L-1:0] d1_valid_r;
  side1_t       d1_r [L];

  logic [W-1:0] qa_h, qa_s, qb_h, qb_s;

  logic [W-1:0]    lbase_a_r, lbase_b_r;
  logic [LY_W-1:0] ly_a_r, ly_b_r;
  logic [W-1:0]    lq_a, lq_b;
  logic [W-1:0]    ld_a_r [L-1];
  logic [W-1:0]    ld_b_r [L-1];

  logic [W-1:0]        a_v [3];
  logic [W-1:0]        b_v [3];
  logic                s3_valid_r;
  side2_t              s3_side_r;
  logic [NUM2_W-1:0]   s3_prod_r [3];

  logic         s4_valid_r;
  side2_t       s4_side_r;
  logic [W-1:0] bq_r [3];
  logic [W-1:0] v    [3];

  // whole front moves unless its last item cannot enter the queue
  assign en = !(s4_valid_r && q_stat.full);
  assign in_stall = !en;

  // accept and clamp percent
  assign p_clamp = (in_blend_percent > PCT_FULL) ? PCT_FULL : in_blend_percent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sc_r <= in_start_color;
      s1_ec_r <= in_end_color;
      s1_p_r <= p_clamp;
    end
  end

  // classify both colours
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a_r <= hci_rgb_info(s1_sc_r);
      s2_b_r <= hci_rgb_info(s1_ec_r);
      s2_side_r.grey_a <= (s1_sc_r[7:0] == s1_sc_r[15:8]) && (s1_sc_r[7:0] == s1_sc_r[23:16]);
      s2_side_r.grey_b <= (s1_ec_r[7:0] == s1_ec_r[15:8]) && (s1_ec_r[7:0] == s1_ec_r[23:16]);
      s2_side_r.p <= s1_p_r;
      s2_side_r.byp <= (s1_p_r == '0) || (s1_p_r == PCT_FULL);
      s2_side_r.color <= (s1_p_r == '0) ? s1_sc_r : s1_ec_r;
    end
  end

  // hue and saturation dividers
  hci_div #(.NUM_W(NUM1_W), .DEN_W(11), .Q_W(W)) u_div_sa (
    .clk(clk), .en(en), .num(NUM1_W'(s2_a_r.d) << FRAC_BITS), .den(11'(s2_a_r.den_s)),
    .q(qa_s)
  );
  hci_div #(.NUM_W(NUM1_W), .DEN_W(11), .Q_W(W)) u_div_ha (
    .clk(clk), .en(en), .num(NUM1_W'(s2_a_r.n) << FRAC_BITS), .den(s2_a_r.sixd), .q(qa_h)
  );
  hci_div #(.NUM_W(NUM1_W), .DEN_W(11), .Q_W(W)) u_div_sb (
    .clk(clk), .en(en), .num(NUM1_W'(s2_b_r.d) << FRAC_BITS), .den(11'(s2_b_r.den_s)),
    .q(qb_s)
  );
  hci_div #(.NUM_W(NUM1_W), .DEN_W(11), .Q_W(W)) u_div_hb (
    .clk(clk), .en(en), .num(NUM1_W'(s2_b_r.n) << FRAC_BITS), .den(s2_b_r.sixd), .q(qb_h)
  );

  // lightness over two stages, then delayed to meet the dividers
  assign lq_a = W'((37'(ly_a_r) * 37'(LM)) >> LM_SH);
  assign lq_b = W'((37'(ly_b_r) * 37'(LM)) >> LM_SH);

  always_ff @(posedge clk) begin
    if (en) begin
      lbase_a_r <= W'(s2_a_r.sum * LQ0);
      lbase_b_r <= W'(s2_b_r.sum * LQ0);
      ly_a_r <= LY_W'(s2_a_r.sum * LR0);
      ly_b_r <= LY_W'(s2_b_r.sum * LR0);
      ld_a_r[0] <= lbase_a_r + lq_a;
      ld_b_r[0] <= lbase_b_r + lq_b;
      for (int i = 1; i < L-1; i++) begin
        ld_a_r[i] <= ld_a_r[i-1];
        ld_b_r[i] <= ld_b_r[i-1];
      end
    end
  end

  // side data alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r <= '0;
    end else if (en) begin
      d1_valid_r <= {d1_valid_r[L-2:0], s2_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= s2_side_r;
      for (int i = 1; i < L; i++) d1_r[i] <= d1_r[i-1];
    end
  end

  // grey colours get zero hue and saturation
  assign a_v[0] = d1_r[L-1].grey_a ? '0 : qa_h;
  assign a_v[1] = d1_r[L-1].grey_a ? '0 : qa_s;
  assign a_v[2] = ld_a_r[L-2];
  assign b_v[0] = d1_r[L-1].grey_b ? '0 : qb_h;
  assign b_v[1] = d1_r[L-1].grey_b ? '0 : qb_s;
  assign b_v[2] = ld_b_r[L-2];

  // distance times percent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= d1_valid_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_side_r.a[k] <= a_v[k];
        s3_side_r.neg[k] <= (b_v[k] < a_v[k]);
        s3_prod_r[k] <= NUM2_W'((b_v[k] < a_v[k]) ? a_v[k] - b_v[k] : b_v[k] - a_v[k])
                        * NUM2_W'(d1_r[L-1].p);
      end
      s3_side_r.byp <= d1_r[L-1].byp;
      s3_side_r.color <= d1_r[L-1].color;
    end
  end

  // divide by one hundred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s3_side_r;
      for (int k = 0; k < 3; k++) begin
        bq_r[k] <= W'(((2*NUM2_W)'(s3_prod_r[k]) * (2*NUM2_W)'(PM)) >> PM_SH);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k] = s4_side_r.neg[k] ? s4_side_r.a[k] - bq_r[k] : s4_side_r.a[k] + bq_r[k];
    end
  end

  // blended word into the queue
  assign q_push = s4_valid_r && en;
  assign push_h = v[0];
  assign push_s = v[1];
  assign push_l = v[2];
  assign push_byp = s4_side_r.byp;
  assign push_color = s4_side_r.color;

endmodule

// ----- hdl/hci_queue.sv -----
module hci_queue
  import hci_pkg::*;
#(
  parameter int DW = 76
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output hci_qstat_t    stat
);

  logic [DW-1:0]       mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign rdata = mem_r[rd_ptr_r];
  assign stat.full = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ----- hdl/hci_back.sv -----
module hci_back
  import hci_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hci_qstat_t             q_stat,
  input  logic [3*FRAC_BITS+3+COLOR_W:0] q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COLOR_W-1:0]     out_mixed_color
);

  localparam int W = FRAC_BITS + 1;
  localparam int CW = W + 6;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] HALF = W'(2 ** (FRAC_BITS - 1));
  localparam logic [W-1:0] THIRD = W'((2 ** FRAC_BITS) / 3);
  localparam logic [W-1:0] TWO_THIRDS = W'((2 ** (FRAC_BITS + 1)) / 3);

  logic en;

  logic [W-1:0]       hd_h, hd_s, hd_l;
  logic               hd_byp;
  logic [COLOR_W-1:0] hd_color;
  logic [W:0]         hr_sum;
  logic [W-1:0]       hue_v [3];

  logic               b1_valid_r;
  logic [W-1:0]       b1_h_r [3];
  logic [W-1:0]       b1_l_r, b1_s_r;
  logic [2*W-1:0]     b1_ls_r;
  logic               b1_byp_r;
  logic [COLOR_W-1:0] b1_color_r;

  logic [W-1:0]        lsh;
  logic [W:0]          m2;
  logic signed [W+1:0] m1;
  logic [W+1:0]        span;
  hci_seg_t            seg [3];
  logic [W-1:0]        tv  [3];

  logic                b2_valid_r;
  logic signed [W+1:0] b2_m1_r;
  logic [W:0]          b2_m2_r;
  logic [W+1:0]        b2_span_r;
  hci_seg_t            b2_seg_r [3];
  logic [W-1:0]        b2_t_r [3];
  logic [W-1:0]        b2_l_r;
  logic                b2_grey_r, b2_byp_r;
  logic [COLOR_W-1:0]  b2_color_r;

  logic                b3_valid_r;
  logic signed [W+1:0] b3_m1_r;
  logic [W:0]          b3_m2_r;
  logic [2*W+1:0]      b3_prod_r [3];
  hci_seg_t            b3_seg_r [3];
  logic [W-1:0]        b3_l_r;
  logic                b3_grey_r, b3_byp_r;
  logic [COLOR_W-1:0]  b3_color_r;

  logic signed [CW-1:0] cv [3];
  logic                 b4_valid_r;
  logic signed [CW-1:0] b4_c_r [3];
  logic                 b4_byp_r;
  logic [COLOR_W-1:0]   b4_color_r;

  logic [7:0]           byte_v [3];
  logic                 b5_valid_r;
  logic [COLOR_W-1:0]   b5_color_r;

  // whole back moves when the output register can take a word
  assign en = !b5_valid_r || !out_stall;
  assign q_pop = en && !q_stat.empty;

  assign {hd_byp, hd_color, hd_h, hd_s, hd_l} = q_data;

  // hue arguments for red, green and blue
  always_comb begin
    hr_sum = {1'b0, hd_h} + {1'b0, THIRD};
    hue_v[0] = (hr_sum > {1'b0, ONE}) ? W'(hr_sum - {1'b0, ONE}) : W'(hr_sum);
    hue_v[1] = hd_h;
    hue_v[2] = (hd_h < THIRD) ? W'({1'b0, hd_h} + {1'b0, ONE} - {1'b0, THIRD})
                              : hd_h - THIRD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
      b3_valid_r <= 1'b0;
      b4_valid_r <= 1'b0;
      b5_valid_r <= 1'b0;
    end else if (en) begin
      b1_valid_r <= !q_stat.empty;
      b2_valid_r <= b1_valid_r;
      b3_valid_r <= b2_valid_r;
      b4_valid_r <= b3_valid_r;
      b5_valid_r <= b4_valid_r;
    end
  end

  // lightness times saturation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) b1_h_r[k] <= hue_v[k];
      b1_l_r <= hd_l;
      b1_s_r <= hd_s;
      b1_ls_r <= (2*W)'(hd_l) * (2*W)'(hd_s);
      b1_byp_r <= hd_byp;
      b1_color_r <= hd_color;
    end
  end

  // m1, m2 and the ramp segment of each channel
  always_comb begin
    lsh = W'(b1_ls_r >> FRAC_BITS);
    if (b1_l_r <= HALF) begin
      m2 = {1'b0, b1_l_r} + {1'b0, lsh};
    end else begin
      m2 = {1'b0, b1_l_r} + {1'b0, b1_s_r} - {1'b0, lsh};
    end
    m1 = $signed({1'b0, b1_l_r, 1'b0}) - $signed({1'b0, m2});
    span = ($signed({1'b0, m2}) > m1) ? $unsigned($signed({1'b0, m2}) - m1) : '0;
    for (int k = 0; k < 3; k++) begin
      if ((W+3)'(b1_h_r[k]) * (W+3)'(6) < (W+3)'(ONE)) begin
        seg[k] = SEG_RISE;
        tv[k] = b1_h_r[k];
      end else if (((W+3)'(b1_h_r[k]) << 1) < (W+3)'(ONE)) begin
        seg[k] = SEG_HIGH;
        tv[k] = '0;
      end else if ((W+3)'(b1_h_r[k]) * (W+3)'(3) < ((W+3)'(ONE) << 1)) begin
        seg[k] = SEG_FALL;
        tv[k] = (TWO_THIRDS >= b1_h_r[k]) ? TWO_THIRDS - b1_h_r[k] : '0;
      end else begin
        seg[k] = SEG_LOW;
        tv[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_m1_r <= m1;
      b2_m2_r <= m2;
      b2_span_r <= span;
      for (int k = 0; k < 3; k++) begin
        b2_seg_r[k] <= seg[k];
        b2_t_r[k] <= tv[k];
      end
      b2_l_r <= b1_l_r;
      b2_grey_r <= (b1_s_r == '0);
      b2_byp_r <= b1_byp_r;
      b2_color_r <= b1_color_r;
    end
  end

  // ramp products
  always_ff @(posedge clk) begin
    if (en) begin
      b3_m1_r <= b2_m1_r;
      b3_m2_r <= b2_m2_r;
      for (int k = 0; k < 3; k++) begin
        b3_prod_r[k] <= (2*W+2)'(b2_span_r) * (2*W+2)'(b2_t_r[k]);
        b3_seg_r[k] <= b2_seg_r[k];
      end
      b3_l_r <= b2_l_r;
      b3_grey_r <= b2_grey_r;
      b3_byp_r <= b2_byp_r;
      b3_color_r <= b2_color_r;
    end
  end

  // channel value from its segment
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [2*W+4:0] p6;
      p6 = ((2*W+5)'(b3_prod_r[k]) << 2) + ((2*W+5)'(b3_prod_r[k]) << 1);
      if (b3_grey_r) begin
        cv[k] = $signed(CW'(b3_l_r));
      end else begin
        case (b3_seg_r[k])
          SEG_RISE, SEG_FALL: cv[k] = CW'(b3_m1_r) + $signed(CW'(p6 >> FRAC_BITS));
          SEG_HIGH:           cv[k] = $signed(CW'(b3_m2_r));
          SEG_LOW:            cv[k] = CW'(b3_m1_r);
          default:            cv[k] = CW'(b3_m1_r);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) b4_c_r[k] <= cv[k];
      b4_byp_r <= b3_byp_r;
      b4_color_r <= b3_color_r;
    end
  end

  // clamp and scale to bytes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [W-1:0] cc;
      logic [W+7:0] sc;
      logic [8:0]   vv;
      if (b4_c_r[k] < 0) begin
        cc = '0;
      end else if (b4_c_r[k] > $signed(CW'(ONE))) begin
        cc = ONE;
      end else begin
        cc = W'(b4_c_r[k]);
      end
      sc = ((W+8)'(cc) << 8) - (W+8)'(cc);
      vv = 9'(sc >> FRAC_BITS);
      byte_v[k] = (vv > 9'd255) ? 8'd255 : vv[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_color_r <= b4_byp_r ? b4_color_r : {byte_v[2], byte_v[1], byte_v[0]};
    end
  end

  assign out_valid = b5_valid_r;
  assign out_mixed_color = b5_color_r;

endmodule

// ----- hdl/hsl_color_interpolator.sv -----
// channel   direction  fields                                         handshake
// in        input      start_color[23:0] end_color[23:0] blend[6:0]   in_valid / in_stall
// out       output     mixed_color[23:0]                              out_valid / out_stall
//
// one word per clock sustained while out_stall stays low; the path runs through
// a 1-bit-per-stage divider pipeline of FRAC_BITS+1 stages for hue and saturation,
// plus 4 front register stages, 1 queue stage and 5 back register stages
// reset clears only valid bits, queue pointers and fill count; there is no clearing pass
// the front stalls only when its last word meets a full 4-entry queue; the back
// stalls as a whole while the output register holds an untaken word
module hsl_color_interpolator
  import hci_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COLOR_W-1:0] in_start_color,
  input  logic [COLOR_W-1:0] in_end_color,
  input  logic [PCT_W-1:0]   in_blend_percent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_mixed_color
);

  localparam int W = FRAC_BITS + 1;
  localparam int QDW = 3 * W + COLOR_W + 1;

  hci_qstat_t         q_stat;
  logic               q_push, q_pop;
  logic [W-1:0]       push_h, push_s, push_l;
  logic               push_byp;
  logic [COLOR_W-1:0] push_color;
  logic [QDW-1:0]     q_rdata;

  // conversion and blend
  hci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_color(in_start_color),
    .in_end_color(in_end_color),
    .in_blend_percent(in_blend_percent),
    .q_stat(q_stat),
    .q_push(q_push),
    .push_h(push_h),
    .push_s(push_s),
    .push_l(push_l),
    .push_byp(push_byp),
    .push_color(push_color)
  );

  // decoupling queue
  hci_queue #(.DW(QDW)) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .wdata({push_byp, push_color, push_h, push_s, push_l}),
    .pop(q_pop),
    .rdata(q_rdata),
    .stat(q_stat)
  );

  // back to rgb
  hci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_stat(q_stat),
    .q_data(q_rdata),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mixed_color(out_mixed_color)
  );

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a full queue with a waiting front word holds off the input
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !q_pop && in_stall) |=> $stable(q_stat))
    else $error("queue state moved while front held");

endmodule
